### src/ssrch_pkg.sv
// Shared constants, types and functions of the suffix search engine.
`timescale 1ns / 1ps
`default_nettype none
package ssrch_pkg;

  localparam int TW_N      = 624;
  localparam int TW_M      = 397;
  localparam int TW_ADDR_W = 10;
  localparam logic [31:0] TW_MULT   = 32'd1812433253;
  localparam logic [31:0] TW_MAG    = 32'h9908b0df;
  localparam logic [31:0] SEED_INIT = 32'd5489;

  localparam int CAND_BYTES = 12;
  localparam int CAND_W     = 8 * CAND_BYTES;
  localparam int MAX_SUFFIX_NIBBLES = 16;

  // Register indexes (byte address divided by 8)
  localparam logic [1:0] REG_SUFFIX  = 2'd0;
  localparam logic [1:0] REG_NIBBLES = 2'd1;
  localparam logic [1:0] REG_SEED    = 2'd2;

  // Twister status toward the controller
  typedef struct packed {
    logic       ready;
    logic       valid;
    logic [7:0] data;
  } tw_stat_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    temper = y ^ (y >> 18);
  endfunction

endpackage
`default_nettype wire

### src/ssrch_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module ssrch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

### src/ssrch_twister.sv
// MT19937 generator around a state RAM: seeding, twist pass and tempered output.
`timescale 1ns / 1ps
`default_nettype none
module ssrch_twister (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        seed_start,
  input  wire logic [31:0] seed_val,
  input  wire logic        next_req,
  output ssrch_pkg::tw_stat_t stat
);
  import ssrch_pkg::*;

  typedef enum logic [7:0] {
    TW_IDLE  = 8'b0000_0001,
    TW_SMUL  = 8'b0000_0010,
    TW_SWR   = 8'b0000_0100,
    TW_LOAD  = 8'b0000_1000,
    TW_HEAD  = 8'b0001_0000,
    TW_TWIST = 8'b0010_0000,
    TW_READ  = 8'b0100_0000,
    TW_OUT   = 8'b1000_0000
  } tw_state_t;

  localparam logic [TW_ADDR_W-1:0] LAST = TW_ADDR_W'(TW_N - 1);
  localparam logic [TW_ADDR_W:0]   NW   = (TW_ADDR_W + 1)'(TW_N);

  tw_state_t state;
  logic [TW_ADDR_W-1:0] i;
  logic [TW_ADDR_W-1:0] idx;   // 0..623; full is a separate flag
  logic                 idx_full;
  logic [31:0] p;
  logic [31:0] prod;
  logic [31:0] cur;

  logic                 we;
  logic [TW_ADDR_W-1:0] waddr;
  logic [31:0]          wdata;
  logic [TW_ADDR_W-1:0] raddr_a;
  logic [TW_ADDR_W-1:0] raddr_b;
  logic [31:0]          rdata_a;
  logic [31:0]          rdata_b;

  logic [31:0] seed_word;
  logic [31:0] y;
  logic [31:0] twist_word;
  logic [TW_ADDR_W:0] a_sum;
  logic [TW_ADDR_W:0] b_sum;
  logic [31:0] tempered;

  ssrch_ram #(.WIDTH(32), .DEPTH(TW_N)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .rdata_a(rdata_a),
    .raddr_b(raddr_b), .rdata_b(rdata_b)
  );

  always_comb begin
    seed_word  = prod + {{(32 - TW_ADDR_W){1'b0}}, i};
    y          = {cur[31], rdata_a[30:0]};
    twist_word = rdata_b ^ (y >> 1) ^ (y[0] ? TW_MAG : 32'd0);
    we      = 1'b0;
    waddr   = i;
    wdata   = seed_word;
    raddr_a = idx;
    raddr_b = '0;
    a_sum   = '0;
    b_sum   = '0;
    case (state)
      TW_IDLE: begin
        we    = seed_start;
        waddr = '0;
        wdata = seed_val;
      end
      TW_SWR: begin
        we = 1'b1;
      end
      TW_LOAD: begin
        raddr_a = '0;
      end
      TW_HEAD: begin
        raddr_a = TW_ADDR_W'(1);
        raddr_b = TW_ADDR_W'(TW_M);
      end
      TW_TWIST: begin
        we    = 1'b1;
        wdata = twist_word;
        // wrap the look-ahead addresses for the following step
        a_sum = {1'b0, i} + (TW_ADDR_W + 1)'(2);
        b_sum = {1'b0, i} + (TW_ADDR_W + 1)'(TW_M + 1);
        raddr_a = (a_sum >= NW) ? TW_ADDR_W'(a_sum - NW) : a_sum[TW_ADDR_W-1:0];
        raddr_b = (b_sum >= NW) ? TW_ADDR_W'(b_sum - NW) : b_sum[TW_ADDR_W-1:0];
      end
      default: begin
        raddr_a = idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= TW_IDLE;
      idx      <= '0;
      idx_full <= 1'b1;
    end else begin
      case (state)
        TW_IDLE: begin
          if (seed_start) begin
            p     <= seed_val;
            i     <= TW_ADDR_W'(1);
            state <= TW_SMUL;
          end else if (next_req) begin
            state <= idx_full ? TW_LOAD : TW_READ;
          end
        end
        TW_SMUL: begin
          prod  <= TW_MULT * (p ^ (p >> 30));
          state <= TW_SWR;
        end
        TW_SWR: begin
          p <= seed_word;
          if (i == LAST) begin
            idx_full <= 1'b1;
            state    <= TW_IDLE;
          end else begin
            i     <= i + 1'b1;
            state <= TW_SMUL;
          end
        end
        TW_LOAD: begin
          state <= TW_HEAD;
        end
        TW_HEAD: begin
          cur   <= rdata_a;
          i     <= '0;
          state <= TW_TWIST;
        end
        TW_TWIST: begin
          cur <= rdata_a;
          if (i == LAST) begin
            idx      <= '0;
            idx_full <= 1'b0;
            state    <= TW_READ;
          end else begin
            i <= i + 1'b1;
          end
        end
        TW_READ: begin
          state <= TW_OUT;
        end
        TW_OUT: begin
          if (idx == LAST) begin
            idx_full <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
          state <= TW_IDLE;
        end
        default: begin
          state <= TW_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    tempered   = temper(rdata_a);
    stat.ready = (state == TW_IDLE);
    stat.valid = (state == TW_OUT);
    stat.data  = tempered[7:0];
  end
endmodule
`default_nettype wire

### src/ssrch_sha.sv
// SHA-256 of a 12-byte candidate on one shared round unit, 64 rounds.
`timescale 1ns / 1ps
`default_nettype none
module ssrch_sha (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ssrch_pkg::CAND_W-1:0] cand,
  output logic                              done,
  output logic [63:0]                       digest_tail
);
  import ssrch_pkg::*;

  typedef enum logic [2:0] {
    H_IDLE = 3'b001,
    H_RUN  = 3'b010,
    H_FIN  = 3'b100
  } sha_state_t;

  sha_state_t state;
  logic [5:0]  rnd;
  logic [31:0] a, b, c, d, e, f, g, hh;
  logic [31:0] w [16];

  logic [31:0] s1, ch, t1, s0, mj, t2, sig0, sig1, w_new;

  always_comb begin
    s1    = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch    = (e & f) ^ (~e & g);
    t1    = hh + s1 + ch + ROUND_K[rnd] + w[0];
    s0    = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    mj    = (a & b) ^ (a & c) ^ (b & c);
    t2    = s0 + mj;
    sig0  = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    sig1  = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + sig0 + w[9] + sig1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        H_IDLE: begin
          if (start) begin
            state <= H_RUN;
          end
        end
        H_RUN: begin
          if (rnd == 6'd63) begin
            state <= H_FIN;
          end
        end
        H_FIN: begin
          done  <= 1'b1;
          state <= H_IDLE;
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == H_IDLE && start) begin
      a <= INIT_H[0]; b <= INIT_H[1]; c <= INIT_H[2]; d <= INIT_H[3];
      e <= INIT_H[4]; f <= INIT_H[5]; g <= INIT_H[6]; hh <= INIT_H[7];
      rnd   <= '0;
      w[0]  <= cand[95:64];
      w[1]  <= cand[63:32];
      w[2]  <= cand[31:0];
      w[3]  <= 32'h8000_0000;
      for (int k = 4; k < 15; k++) begin
        w[k] <= '0;
      end
      w[15] <= 32'(CAND_W);
    end else if (state == H_RUN) begin
      hh <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
      rnd <= rnd + 1'b1;
      for (int k = 0; k < 15; k++) begin
        w[k] <= w[k + 1];
      end
      w[15] <= w_new;
    end else if (state == H_FIN) begin
      digest_tail <= {INIT_H[6] + g, INIT_H[7] + hh};
    end
  end
endmodule
`default_nettype wire

### src/sha256_suffix_search.sv
// Top level of the proof-of-work suffix search engine.
// An accepted tick becomes the result item through 12 twister reads, 64 SHA-256
//   rounds, finish, done and output load; every 52nd item adds a twist pass
//   over the state RAM.
// Items are worked on one at a time, bound by the single round unit and RAM port.
// Reset: synchronous; the state RAM is seeded with 5489, and a seed write made while
//   the twister is idle reseeds the same way; no item is accepted while seeding.
`timescale 1ns / 1ps
`default_nettype none
module sha256_suffix_search (
  input  wire logic         clk,
  input  wire logic         rst,
  // item in
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [0] attempt_tick, rest zero
  // result item out
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [167:0]      m_tdata,   // [0] match, [32:1] candidate_head,
                                       // [96:33] candidate_tail, [160:97] digest_tail
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import ssrch_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GEN  = 4'b0010,
    S_HASH = 4'b0100,
    S_WAIT = 4'b1000
  } top_state_t;

  top_state_t state;

  // configuration registers
  logic [63:0] suffix_value;
  logic [4:0]  suffix_nibbles;
  logic [31:0] seed;
  logic        boot;         // kicks off the seeding pass after reset

  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        seed_start;

  // candidate collection
  logic [CAND_W-1:0] cand;
  logic [CAND_W-1:0] cand_next;
  logic [3:0]        byte_cnt;

  tw_stat_t    tw;
  logic        sha_start;
  logic        sha_done;
  logic [63:0] digest_tail;

  logic [4:0]  n_eff;
  logic        match;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:3];
  assign cfg_wr  = psel & penable & pwrite;
  assign seed_start = boot | (cfg_wr && cfg_idx == REG_SEED);

  always_comb begin
    case (cfg_idx)
      REG_SUFFIX:  prdata = suffix_value;
      REG_NIBBLES: prdata = {59'd0, suffix_nibbles};
      REG_SEED:    prdata = {32'd0, seed};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      suffix_value   <= '0;
      suffix_nibbles <= 5'd1;
      seed           <= SEED_INIT;
      boot           <= 1'b1;
    end else begin
      boot <= 1'b0;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_SUFFIX:  suffix_value   <= pwdata;
          REG_NIBBLES: suffix_nibbles <= pwdata[4:0];
          REG_SEED:    seed           <= pwdata[31:0];
          default:     ;
        endcase
      end
    end
  end

  // the seed value goes straight from the bus on a write, else from reset
  ssrch_twister u_twister (
    .clk(clk), .rst(rst),
    .seed_start(seed_start),
    .seed_val(boot ? SEED_INIT : pwdata[31:0]),
    .next_req(state == S_GEN),
    .stat(tw)
  );

  // shift each new byte in low, so byte 0 lands most significant
  assign cand_next = {cand[CAND_W-9:0], tw.data};
  assign sha_start = (state == S_GEN) && tw.valid && (byte_cnt == 4'(CAND_BYTES - 1));

  ssrch_sha u_sha (
    .clk(clk), .rst(rst),
    .start(sha_start), .cand(cand_next),
    .done(sha_done), .digest_tail(digest_tail)
  );

  // hold off new items while seeding, twisting or still busy on one
  assign s_tready = (state == S_IDLE) && tw.ready && !boot;

  // clamp the nibble count to 1..16 and compare nibble by nibble
  always_comb begin
    n_eff = suffix_nibbles;
    if (suffix_nibbles == 5'd0) begin
      n_eff = 5'd1;
    end else if (suffix_nibbles > 5'(MAX_SUFFIX_NIBBLES)) begin
      n_eff = 5'(MAX_SUFFIX_NIBBLES);
    end
    match = 1'b1;
    for (int k = 0; k < MAX_SUFFIX_NIBBLES; k++) begin
      if (5'(k) < n_eff && digest_tail[4*k +: 4] != suffix_value[4*k +: 4]) begin
        match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      byte_cnt <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          byte_cnt <= '0;
          // a tick of zero is taken and dropped
          if (s_tvalid && s_tready && s_tdata[0]) begin
            state <= S_GEN;
          end
        end
        S_GEN: begin
          if (tw.valid) begin
            byte_cnt <= byte_cnt + 1'b1;
            if (sha_start) begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (sha_done) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // load the result once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_GEN && tw.valid) begin
      cand <= cand_next;
    end
    if (state == S_WAIT && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'd0, digest_tail, cand[63:0], cand[95:64], match};
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_byte_in_gen: assert property (@(posedge clk) disable iff (rst)
    tw.valid |-> state == S_GEN)
    else $error("twister byte outside candidate collection");
  a_done_in_hash: assert property (@(posedge clk) disable iff (rst)
    sha_done |-> state == S_HASH)
    else $error("hash finished outside hash phase");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT && !m_tvalid |=> m_tvalid && state == S_IDLE)
    else $error("result not loaded from wait state");
endmodule
`default_nettype wire
